### hdl/rmd_pkg.sv
`timescale 1ns / 1ps

package rmd_pkg;

  // framing constants
  localparam int MARKER_BYTES          = 16;
  localparam int WORD_BYTES            = 4;
  localparam int LEN_SHIFT             = 20;
  localparam int HASH_HEADER_WORDS_DEF = 4;
  localparam int FIFO_DEPTH_DEF        = 2;

  // config register reset values
  localparam logic [31:0] SIGNATURE_RST      = 32'd0;
  localparam logic [31:0] MAX_HEADER_LEN_RST = 32'd4096;
  localparam logic [31:0] MAX_DATA_LEN_RST   = 32'd16777216;

  // config register indexes
  typedef enum logic [1:0] {
    CFG_SIGNATURE      = 2'd0,
    CFG_MAX_HEADER_LEN = 2'd1,
    CFG_MAX_DATA_LEN   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_MARKER = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2,
    PH_DEAD   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_MARKER_OK  = 2'd0,
    KIND_HEADER     = 2'd1,
    KIND_DATA       = 2'd2,
    KIND_MARKER_BAD = 2'd3
  } kind_t;

  typedef struct packed {
    logic [31:0] signature;
    logic [31:0] max_header_len;
    logic [31:0] max_data_len;
  } rmd_cfg_t;

  // one classified request from front to back
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload;
    logic [31:0] hdr_len;
    logic [31:0] dat_len;
    logic [31:0] hash_word;
    logic        hash_load;
    logic        hash_xor;
    logic        hash_emit;
    logic        last;
  } rmd_entry_t;

endpackage

### hdl/rmd_front.sv
`timescale 1ns / 1ps

module rmd_front #(
  parameter int HASH_HEADER_WORDS = rmd_pkg::HASH_HEADER_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rmd_pkg::rmd_cfg_t   cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                q_full,
  output logic                push,
  output rmd_pkg::rmd_entry_t entry
);

  localparam int HashBytes   = HASH_HEADER_WORDS * rmd_pkg::WORD_BYTES;
  localparam int MarkLastIdx = rmd_pkg::MARKER_BYTES - 1;

  rmd_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] mw0_r, mw0_nxt, mw1_r, mw1_nxt, mw2_r, mw2_nxt;
  logic [31:0] hl_r, hl_nxt, dl_r, dl_nxt;

  logic        accept;
  logic [1:0]  lane;
  logic [31:0] word_asm;
  logic [31:0] cnt_inc;
  logic [31:0] expect_ck;
  logic        marker_end, mark_ok, hdr_final, dat_final, in_hash, hash_last;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign lane     = cnt_r[1:0];
  assign cnt_inc  = cnt_r + 32'd1;

  // little-endian byte lanes, bytes above the current one read as zero
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (2'(k) == lane) begin
        word_asm[8*k +: 8] = in_byte;
      end else if (2'(k) < lane) begin
        word_asm[8*k +: 8] = word_r[8*k +: 8];
      end else begin
        word_asm[8*k +: 8] = 8'h00;
      end
    end
  end

  assign marker_end = (cnt_r == 32'(MarkLastIdx));
  assign expect_ck  = mw0_r + ((mw1_r << rmd_pkg::LEN_SHIFT) ^ mw2_r);
  assign mark_ok    = (mw0_r == cfg.signature) && (mw1_r <= cfg.max_header_len) &&
                      (mw2_r <= cfg.max_data_len) && (word_asm == expect_ck);
  assign hdr_final  = (cnt_inc == hl_r);
  assign dat_final  = (cnt_inc == dl_r);
  assign in_hash    = (cnt_r < 32'(HashBytes));
  assign hash_last  = (cnt_r == 32'(HashBytes - 1));

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      rmd_pkg::PH_MARKER: begin
        if (accept && marker_end) begin
          if (!mark_ok) begin
            phase_nxt = rmd_pkg::PH_DEAD;
          end else if (mw1_r != 32'd0) begin
            phase_nxt = rmd_pkg::PH_HEADER;
          end else if (mw2_r != 32'd0) begin
            phase_nxt = rmd_pkg::PH_DATA;
          end else begin
            phase_nxt = rmd_pkg::PH_MARKER;
          end
        end
      end
      rmd_pkg::PH_HEADER: begin
        if (accept && hdr_final) begin
          phase_nxt = (dl_r != 32'd0) ? rmd_pkg::PH_DATA : rmd_pkg::PH_MARKER;
        end
      end
      rmd_pkg::PH_DATA: begin
        if (accept && dat_final) begin
          phase_nxt = rmd_pkg::PH_MARKER;
        end
      end
      rmd_pkg::PH_DEAD: phase_nxt = rmd_pkg::PH_DEAD;
      default:          phase_nxt = phase_r;
    endcase
  end

  // classification and requests
  always_comb begin
    cnt_nxt  = cnt_r;
    word_nxt = word_r;
    mw0_nxt  = mw0_r;
    mw1_nxt  = mw1_r;
    mw2_nxt  = mw2_r;
    hl_nxt   = hl_r;
    dl_nxt   = dl_r;
    push     = 1'b0;
    entry    = '0;
    case (phase_r)
      rmd_pkg::PH_MARKER: begin
        if (accept) begin
          word_nxt = word_asm;
          cnt_nxt  = cnt_inc;
          if (lane == 2'd3) begin
            case (cnt_r[3:2])
              2'd0:    mw0_nxt = word_asm;
              2'd1:    mw1_nxt = word_asm;
              2'd2:    mw2_nxt = word_asm;
              default: ;
            endcase
          end
          if (marker_end) begin
            cnt_nxt       = 32'd0;
            push          = 1'b1;
            entry.hdr_len = mw1_r;
            entry.dat_len = mw2_r;
            if (mark_ok) begin
              entry.kind      = rmd_pkg::KIND_MARKER_OK;
              entry.hash_word = mw0_r ^ mw1_r ^ mw2_r ^ word_asm;
              entry.hash_load = 1'b1;
              entry.hash_emit = (mw1_r == 32'd0);
              entry.last      = (mw1_r == 32'd0) && (mw2_r == 32'd0);
              hl_nxt          = mw1_r;
              dl_nxt          = mw2_r;
            end else begin
              entry.kind = rmd_pkg::KIND_MARKER_BAD;
              entry.last = 1'b1;
            end
          end
        end
      end
      rmd_pkg::PH_HEADER: begin
        if (accept) begin
          push          = 1'b1;
          entry.kind    = rmd_pkg::KIND_HEADER;
          entry.payload = in_byte;
          entry.last    = hdr_final && (dl_r == 32'd0);
          cnt_nxt       = hdr_final ? 32'd0 : cnt_inc;
          if (in_hash) begin
            word_nxt = word_asm;
            if (lane == 2'd3 || hdr_final) begin
              entry.hash_word = word_asm;
              entry.hash_xor  = 1'b1;
            end
            entry.hash_emit = hash_last || hdr_final;
          end
        end
      end
      rmd_pkg::PH_DATA: begin
        if (accept) begin
          push          = 1'b1;
          entry.kind    = rmd_pkg::KIND_DATA;
          entry.payload = in_byte;
          entry.last    = dat_final;
          cnt_nxt       = dat_final ? 32'd0 : cnt_inc;
        end
      end
      rmd_pkg::PH_DEAD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rmd_pkg::PH_MARKER;
      cnt_r   <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    mw0_r  <= mw0_nxt;
    mw1_r  <= mw1_nxt;
    mw2_r  <= mw2_nxt;
    hl_r   <= hl_nxt;
    dl_r   <= dl_nxt;
  end

`ifndef SYNTH
  a_bad_marker_kills: assert property (@(posedge clk) disable iff (!rst_n)
    push && entry.kind == rmd_pkg::KIND_MARKER_BAD |=> phase_r == rmd_pkg::PH_DEAD)
    else $error("rejected marker did not stop the stream");
`endif

endmodule

### hdl/rmd_fifo.sv
`timescale 1ns / 1ps

module rmd_fifo #(
  parameter int DEPTH = rmd_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rmd_pkg::rmd_entry_t wr_data,
  output logic                full,
  input  logic                pop,
  output logic                rd_valid,
  output rmd_pkg::rmd_entry_t rd_data
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  rmd_pkg::rmd_entry_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full     = (cnt_r == CntW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("request pushed into a full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

### hdl/rmd_back.sv
`timescale 1ns / 1ps

module rmd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  rmd_pkg::rmd_entry_t q_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output rmd_pkg::kind_t      out_kind,
  output logic [7:0]          out_payload,
  output logic [31:0]         out_hdr_len,
  output logic [31:0]         out_dat_len,
  output logic                out_hash_valid,
  output logic [31:0]         out_hash,
  output logic                out_last
);

  logic           out_valid_r, out_valid_nxt;
  logic [31:0]    accum_r, accum_nxt;
  rmd_pkg::kind_t kind_r;
  logic [7:0]     payload_r;
  logic [31:0]    hdr_len_r, dat_len_r, hash_r;
  logic           hash_valid_r, last_r;

  assign pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    if (q_data.hash_load) begin
      accum_nxt = q_data.hash_word;
    end else if (q_data.hash_xor) begin
      accum_nxt = accum_r ^ q_data.hash_word;
    end else begin
      accum_nxt = accum_r;
    end
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      accum_r     <= 32'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        accum_r <= accum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r       <= q_data.kind;
      payload_r    <= q_data.payload;
      hdr_len_r    <= q_data.hdr_len;
      dat_len_r    <= q_data.dat_len;
      hash_valid_r <= q_data.hash_emit;
      hash_r       <= q_data.hash_emit ? accum_nxt : 32'd0;
      last_r       <= q_data.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_payload    = payload_r;
  assign out_hdr_len    = hdr_len_r;
  assign out_dat_len    = dat_len_r;
  assign out_hash_valid = hash_valid_r;
  assign out_hash       = hash_r;
  assign out_last       = last_r;

`ifndef SYNTH
  a_hash_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && hash_valid_r |->
      kind_r == rmd_pkg::KIND_MARKER_OK || kind_r == rmd_pkg::KIND_HEADER)
    else $error("frame hash reported on a data or rejected result");
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == rmd_pkg::KIND_MARKER_BAD |-> last_r && !hash_valid_r)
    else $error("rejected marker result not closing the frame");
`endif

endmodule

### hdl/rpc_marker_deframer_top.sv
`timescale 1ns / 1ps

// rpc marker deframer: splits a byte stream into frames, each opened by a 16-byte
// little-endian marker (signature, header length, data length, checksum). on the
// last marker byte the marker is checked against the signature register, the two
// length limits and checksum = signature + ((header length << 20) ^ data length);
// an accepted marker gives a kind 0 result with both lengths, then every header
// byte (kind 1) and data byte (kind 2) comes out tagged, and the last result of a
// frame carries tlast. a frame hash (xor of the four marker words and the first
// HASH_HEADER_WORDS little-endian header words, short words zero-filled) shows up
// with hash_valid on the kind 0 result for an empty header, else on the last
// hashed header byte. a rejected marker gives one kind 3 result with tlast and the
// block then swallows all input until reset. the first fifteen marker bytes give
// no result. throughput is one byte per cycle while the request queue is not
// full: the front classifies one byte per cycle, the marker check being the
// widest path there (add and compare on the final marker byte), and the back
// drains one request per cycle from that queue into the output register, which
// drives out_tvalid, while it is empty or out_tready is high. the queue absorbs
// output stalls; in_tready drops only when it is full. config writes go through
// cfg_we/cfg_addr/cfg_wdata (0 signature, 1 max header length, 2 max data length;
// other indexes ignored) and should be made only while the block is idle.
module rpc_marker_deframer_top #(
  parameter int HASH_HEADER_WORDS = rmd_pkg::HASH_HEADER_WORDS_DEF,
  parameter int FIFO_DEPTH        = rmd_pkg::FIFO_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // input byte stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] in_byte
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // [7:0] payload_byte, [39:8] header_length,
                                   // [71:40] data_length, [103:72] frame_hash
  output logic [2:0]   out_tuser,  // [1:0] kind, [2] hash_valid
  output logic         out_tlast,  // last_in_frame
  // config write port
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  rmd_pkg::rmd_cfg_t   cfg_r;
  rmd_pkg::rmd_entry_t push_entry, pop_entry;
  logic                push, pop, q_full, q_valid;

  rmd_pkg::kind_t out_kind;
  logic [7:0]     out_payload;
  logic [31:0]    out_hdr_len, out_dat_len, out_hash;
  logic           out_hash_valid;

  // config registers, unknown indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.signature      <= rmd_pkg::SIGNATURE_RST;
      cfg_r.max_header_len <= rmd_pkg::MAX_HEADER_LEN_RST;
      cfg_r.max_data_len   <= rmd_pkg::MAX_DATA_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        rmd_pkg::CFG_SIGNATURE:      cfg_r.signature      <= cfg_wdata;
        rmd_pkg::CFG_MAX_HEADER_LEN: cfg_r.max_header_len <= cfg_wdata;
        rmd_pkg::CFG_MAX_DATA_LEN:   cfg_r.max_data_len   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front: byte framing, marker check, hash word assembly
  rmd_front #(
    .HASH_HEADER_WORDS (HASH_HEADER_WORDS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .q_full   (q_full),
    .push     (push),
    .entry    (push_entry)
  );

  // request queue between front and back
  rmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_data  (push_entry),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_data  (pop_entry)
  );

  // back: hash accumulation and output register
  rmd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (pop_entry),
    .pop            (pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_kind       (out_kind),
    .out_payload    (out_payload),
    .out_hdr_len    (out_hdr_len),
    .out_dat_len    (out_dat_len),
    .out_hash_valid (out_hash_valid),
    .out_hash       (out_hash),
    .out_last       (out_tlast)
  );

  assign out_tdata = {out_hash, out_dat_len, out_hdr_len, out_payload};
  assign out_tuser = {out_hash_valid, out_kind};

endmodule
